FILE: hdl/heap_sorter_unit_macros.svh
// assertion macros shared by the heap sorter checkers
// expects clk and arst_n in the scope where a macro is used
`ifndef HEAP_SORTER_UNIT_MACROS_SVH
`define HEAP_SORTER_UNIT_MACROS_SVH

// consequent in the same cycle
`define HSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the next cycle
`define HSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/hs_pkg.sv
// shared types, constants and the order function of the heap sorter
// no dependencies
`default_nettype none

package hs_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int KEY_BITS  = 32;
	localparam int KEY_IN_W  = 32;
	localparam int IDX_W     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CNT_W     = $clog2(MAX_KEYS + 1);
	localparam int CFG_IDX_W = 1;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SORT_DESCENDING = 1'b0,
		REG_KEYS_SIGNED     = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_FETCH,
		ST_HOLD,
		ST_CHECK,
		ST_CMP,
		ST_NEXT,
		ST_XREAD,
		ST_XSWAP,
		ST_ORD,
		ST_OLD
	} hs_state_t;

	typedef struct packed {
		logic load;
		logic build_init;
		logic rd_root;
		logic hold_sift;
		logic rd_children;
		logic cmp_step;
		logic write_sift;
		logic build_next;
		logic extract_init;
		logic extract_next;
		logic rd_swap;
		logic swap;
		logic out_init;
		logic rd_out;
		logic out_load;
	} hs_cmd_t;

	typedef struct packed {
		logic n_lt2;
		logic has_child;
		logic sift_stop;
		logic idx_is1;
		logic out_free;
		logic out_last;
	} hs_status_t;

	// unsigned rank whose natural order is the output order
	function automatic key_t rank_of(input key_t k, input logic desc, input logic sgn);
		key_t r;
		r = k;
		if (sgn) begin
			r[KEY_BITS-1] = ~r[KEY_BITS-1];
		end
		if (desc) begin
			r = ~r;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/hs_ctrl.sv
// sequencer of the heap sorter: load, heap build, extraction, output
// depends on hs_pkg; drives commands into hs_datapath
`default_nettype none

module hs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               last_in,
	output logic                    in_stall,
	output hs_pkg::hs_cmd_t         cmd,
	input  wire hs_pkg::hs_status_t status
);
	import hs_pkg::*;

	hs_state_t state_q, state_d;
	logic      extract_q, extract_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			extract_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			extract_q <= extract_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		extract_d = extract_q;
		cmd       = '0;
		in_stall  = (state_q != ST_LOAD);
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_in) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				if (status.n_lt2) begin
					cmd.out_init = 1'b1;
					state_d      = ST_ORD;
				end else begin
					cmd.build_init = 1'b1;
					extract_d      = 1'b0;
					state_d        = ST_FETCH;
				end
			end
			ST_FETCH: begin
				cmd.rd_root = 1'b1;
				state_d     = ST_HOLD;
			end
			ST_HOLD: begin
				cmd.hold_sift = 1'b1;
				state_d       = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.has_child) begin
					cmd.rd_children = 1'b1;
					state_d         = ST_CMP;
				end else begin
					cmd.write_sift = 1'b1;
					state_d        = ST_NEXT;
				end
			end
			ST_CMP: begin
				cmd.cmp_step = 1'b1;
				state_d      = status.sift_stop ? ST_NEXT : ST_CHECK;
			end
			ST_NEXT: begin
				if (!extract_q) begin
					if (status.idx_is1) begin
						cmd.extract_init = 1'b1;
						extract_d        = 1'b1;
						state_d          = ST_XREAD;
					end else begin
						cmd.build_next = 1'b1;
						state_d        = ST_FETCH;
					end
				end else begin
					if (status.idx_is1) begin
						cmd.out_init = 1'b1;
						state_d      = ST_ORD;
					end else begin
						cmd.extract_next = 1'b1;
						state_d          = ST_XREAD;
					end
				end
			end
			ST_XREAD: begin
				cmd.rd_swap = 1'b1;
				state_d     = ST_XSWAP;
			end
			ST_XSWAP: begin
				cmd.swap = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_ORD: begin
				cmd.rd_out = 1'b1;
				state_d    = ST_OLD;
			end
			ST_OLD: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = status.out_last ? ST_LOAD : ST_ORD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/hs_datapath.sv
// heap sorter datapath: key memory, sift registers, counters, output register
// depends on hs_pkg; sequenced by hs_ctrl
`default_nettype none

module hs_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire hs_pkg::hs_cmd_t              cmd,
	output hs_pkg::hs_status_t                status,
	input  wire logic                         cfg_valid,
	input  wire logic [hs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                         cfg_data,
	input  wire logic [hs_pkg::KEY_IN_W-1:0]  key_in,
	input  wire logic                         last_in,
	output logic [hs_pkg::KEY_IN_W-1:0]       sorted_key,
	output logic                              last_out,
	output logic                              overflow,
	output logic                              out_valid,
	input  wire logic                         out_stall
);
	import hs_pkg::*;

	key_t mem [MAX_KEYS];

	logic sort_descending_q, keys_signed_q;
	cnt_t count_q, n_q, end_q;
	logic overflowed_q, ovf_run_q;
	idx_t root_q, idx_q, k_q;
	key_t rd_a_q, rd_b_q, sift_key_q;
	key_t out_key_q;
	logic out_last_q, out_ovf_q, out_valid_q;

	logic full;
	idx_t child_idx, right_idx, big_idx;
	cnt_t right_cnt;
	logic has_right, big_right, sift_stop;
	key_t big_key;

	logic we, rd_a_en, rd_b_en;
	idx_t waddr, addr_a, addr_b;
	key_t wdata;

	assign full      = (count_q == CNT_W'(MAX_KEYS));
	assign child_idx = IDX_W'({root_q, 1'b1});
	assign right_cnt = CNT_W'(child_idx) + CNT_W'(1);
	assign right_idx = right_cnt[IDX_W-1:0];
	assign has_right = (right_cnt < end_q);
	assign big_right = has_right && (rank_of(rd_a_q, sort_descending_q, keys_signed_q)
		< rank_of(rd_b_q, sort_descending_q, keys_signed_q));
	assign big_key   = big_right ? rd_b_q : rd_a_q;
	assign big_idx   = big_right ? right_idx : child_idx;
	assign sift_stop = (rank_of(sift_key_q, sort_descending_q, keys_signed_q)
		>= rank_of(big_key, sort_descending_q, keys_signed_q));

	always_comb begin
		status.n_lt2     = (n_q < CNT_W'(2));
		status.has_child = (CNT_W'(root_q) < (end_q >> 1));
		status.sift_stop = sift_stop;
		status.idx_is1   = (idx_q == IDX_W'(1));
		status.out_free  = !out_valid_q || !out_stall;
		status.out_last  = ((CNT_W'(k_q) + CNT_W'(1)) == n_q);
	end

	// memory port selection
	always_comb begin
		we      = 1'b0;
		waddr   = root_q;
		wdata   = sift_key_q;
		rd_a_en = cmd.rd_root | cmd.rd_children | cmd.rd_swap | cmd.rd_out;
		rd_b_en = cmd.rd_children | cmd.rd_swap;
		addr_a  = k_q;
		addr_b  = cmd.rd_children ? right_idx : idx_q;
		if (cmd.rd_root) begin
			addr_a = root_q;
		end else if (cmd.rd_children) begin
			addr_a = child_idx;
		end else if (cmd.rd_swap) begin
			addr_a = '0;
		end
		if (cmd.load) begin
			we    = !full;
			waddr = count_q[IDX_W-1:0];
			wdata = KEY_BITS'(key_in);
		end else if (cmd.cmp_step) begin
			we    = 1'b1;
			wdata = sift_stop ? sift_key_q : big_key;
		end else if (cmd.write_sift) begin
			we = 1'b1;
		end else if (cmd.swap) begin
			we    = 1'b1;
			waddr = idx_q;
			wdata = rd_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_a_en) begin
			rd_a_q <= mem[addr_a];
		end
		if (rd_b_en) begin
			rd_b_q <= mem[addr_b];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.hold_sift) begin
			sift_key_q <= rd_a_q;
		end else if (cmd.swap) begin
			sift_key_q <= rd_b_q;
		end
		if (cmd.out_load) begin
			out_key_q  <= rd_a_q;
			out_last_q <= status.out_last;
			out_ovf_q  <= ovf_run_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_descending_q <= 1'b0;
			keys_signed_q     <= 1'b0;
			count_q           <= '0;
			overflowed_q      <= 1'b0;
			n_q               <= '0;
			ovf_run_q         <= 1'b0;
			end_q             <= '0;
			root_q            <= '0;
			idx_q             <= '0;
			k_q               <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_SORT_DESCENDING: sort_descending_q <= cfg_data;
					REG_KEYS_SIGNED:     keys_signed_q     <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				if (last_in) begin
					// close the set; a dropped closing key still ends it
					n_q          <= full ? count_q : count_q + CNT_W'(1);
					ovf_run_q    <= overflowed_q | full;
					count_q      <= '0;
					overflowed_q <= 1'b0;
				end else if (full) begin
					overflowed_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.build_init) begin
				end_q  <= n_q;
				idx_q  <= IDX_W'(n_q >> 1);
				root_q <= IDX_W'((n_q >> 1) - CNT_W'(1));
			end
			if (cmd.cmp_step && !sift_stop) begin
				root_q <= big_idx;
			end
			if (cmd.build_next) begin
				idx_q  <= idx_q - IDX_W'(1);
				root_q <= idx_q - IDX_W'(2);
			end
			if (cmd.extract_init) begin
				idx_q <= IDX_W'(n_q - CNT_W'(1));
			end
			if (cmd.extract_next) begin
				idx_q <= idx_q - IDX_W'(1);
			end
			if (cmd.swap) begin
				root_q <= '0;
				end_q  <= CNT_W'(idx_q);
			end
			if (cmd.out_init) begin
				k_q <= '0;
			end
			if (cmd.out_load) begin
				k_q         <= k_q + IDX_W'(1);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sorted_key = KEY_IN_W'(out_key_q);
	assign last_out   = out_last_q;
	assign overflow   = out_ovf_q;
	assign out_valid  = out_valid_q;

endmodule

`default_nettype wire

FILE: hdl/heap_sorter_unit.sv
// heap sorter top level: collects a key set, heapsorts it, emits the run
// In: key_in/last_in with in_valid/in_stall; a transfer happens when valid is high and
// stall low. Keys are stored one per cycle until a key marked last_in closes the set.
// Up to 64 keys are held; further keys are dropped and overflow is set on every
// result of that run. Out: sorted_key/last_out/overflow with out_valid/out_stall,
// one result per stored key, last_out on the final one.
// Config: cfg_valid/cfg_ready write cfg_index/cfg_data (index 0 descending order,
// index 1 signed keys); the user must write only while idle, which the block does
// not enforce. cfg_ready is always high. Timing: in_stall is high from the closing
// transfer until the last result is in the output register. The sort runs on one key
// memory port pair: heap build and extraction sift keys down the heap, then each
// result is read from memory and loaded into the output register before the next one
// is read. A set of one key skips the sort. When out_stall is high while a result is
// valid, the output register holds and the sequencer waits before loading the next
// result. Reset clears the counters, flags, config and the output valid.
`default_nettype none

module heap_sorter_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [hs_pkg::KEY_IN_W-1:0]  key_in,
	input  wire logic                         last_in,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	output logic [hs_pkg::KEY_IN_W-1:0]       sorted_key,
	output logic                              last_out,
	output logic                              overflow,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [hs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                         cfg_data
);
	import hs_pkg::*;

	hs_cmd_t    cmd;
	hs_status_t status;

	assign cfg_ready = 1'b1;

	hs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last_in  (last_in),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	hs_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.key_in     (key_in),
		.last_in    (last_in),
		.sorted_key (sorted_key),
		.last_out   (last_out),
		.overflow   (overflow),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

endmodule

`default_nettype wire

FILE: hdl/hs_checker.sv
// port-level checks of the heap sorter, bound to heap_sorter_unit
// depends on heap_sorter_unit_macros.svh
`default_nettype none

`include "heap_sorter_unit_macros.svh"

module hs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        last_in,
	input wire logic [31:0] sorted_key,
	input wire logic        last_out,
	input wire logic        overflow,
	input wire logic        out_valid,
	input wire logic        out_stall
);

	// a stalled result holds
	`HSU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sorted_key) && $stable(last_out) && $stable(overflow), "stalled result changed")

	// the closing transfer ends loading, so input is stalled next
	`HSU_ASSERT_NEXT(a_close_stalls, in_valid && !in_stall && last_in, in_stall, "input taken after closing key")

	// no input while a run is still being emitted
	`HSU_ASSERT_NOW(a_run_stalls, out_valid && !last_out, in_stall, "input open during a run")

	// overflow is the same on every result of one run
	`HSU_ASSERT_NEXT(a_ovf_steady, out_valid && !out_stall && !last_out, !out_valid || (overflow == $past(overflow)), "overflow changed within a run")

endmodule

bind heap_sorter_unit hs_checker u_hs_checker (.*);

`default_nettype wire
